@@ rtl/exls_pkg.sv @@
// ----------------------------------------------------------------------------
// exls_pkg
// Shared types and widths for the expression lexer stream block.
// ----------------------------------------------------------------------------
package exls_pkg;

  // position and length widths
  localparam int unsigned POS_BITS = 16;
  localparam int unsigned LEN_BITS = 8;

  // token kinds as seen on the result channel
  typedef enum logic [3:0] {
    KIND_NUMBER = 4'd0,
    KIND_IDENT  = 4'd1,
    KIND_ASSIGN = 4'd2,
    KIND_SEMI   = 4'd3,
    KIND_PLUS   = 4'd4,
    KIND_MINUS  = 4'd5,
    KIND_MUL    = 4'd6,
    KIND_DIV    = 4'd7,
    KIND_LPAREN = 4'd8,
    KIND_RPAREN = 4'd9,
    KIND_END    = 4'd10,
    KIND_ERROR  = 4'd11
  } tok_kind_e;

  // one result token
  typedef struct packed {
    tok_kind_e             kind;
    logic [POS_BITS-1:0]   line;
    logic [POS_BITS-1:0]   column;
    logic [LEN_BITS-1:0]   len;
    logic                  last;
  } token_t;

  // up to two tokens produced by one transfer, first one in slot first
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } scan_out_t;

endpackage

@@ rtl/expression_lexer_stream.sv @@
// ----------------------------------------------------------------------------
// expression_lexer_stream
// Streaming lexer for a small arithmetic-expression language: one byte or
// end-of-text marker per input transfer, tokens with position and length
// out.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------
//   in      | input     | in_valid_i/in_ready_o  | char_in_i, end_of_text_i
//   out     | output    | out_valid_o/out_ready_i| token_kind_o, start_line_o,
//           |           |                        | start_column_o,
//           |           |                        | token_length_o, last_of_run_o
//
// A byte is classified and the scan state updated in the cycle of its
// transfer; its first token appears on the output in the next cycle.
// One input per cycle while each transfer yields at most one token and the
// output accepts; a transfer that yields two tokens blocks input until
// the second token leaves the spare slot of the result queue.
// Reset returns position to line 1, column 1 and empties the queue.
// Output stalls propagate to in_ready_o through the two-slot queue.
// ----------------------------------------------------------------------------
module expression_lexer_stream (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    char_in_i,
  input  logic                          end_of_text_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [3:0]                    token_kind_o,
  output logic [exls_pkg::POS_BITS-1:0] start_line_o,
  output logic [exls_pkg::POS_BITS-1:0] start_column_o,
  output logic [exls_pkg::LEN_BITS-1:0] token_length_o,
  output logic                          last_of_run_o
);
  import exls_pkg::*;

  logic      fire;
  logic      room;
  scan_out_t scan;
  token_t    head;

  assign in_ready_o = room;
  assign fire       = in_valid_i && room;

  // lexer state and classification
  exls_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .char_in_i     (char_in_i),
    .end_of_text_i (end_of_text_i),
    .scan_o        (scan)
  );

  // result queue
  exls_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .scan_i      (scan),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign token_kind_o   = head.kind;
  assign start_line_o   = head.line;
  assign start_column_o = head.column;
  assign token_length_o = head.len;
  assign last_of_run_o  = head.last;

  // end of text always yields a token on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && end_of_text_i |=> out_valid_o)
    else $error("end of text transfer produced no token");

  // a non-final token is always followed by the final token of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_run_o |=> out_valid_o && last_of_run_o)
    else $error("second token of a run missing");

  // a two-token transfer pairs a number or identifier with a final end, error or operator token
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (scan.count == 2'd2) |->
      (scan.first.kind == KIND_NUMBER || scan.first.kind == KIND_IDENT) &&
      scan.second.last && !scan.first.last)
    else $error("malformed two-token run");

endmodule

@@ rtl/exls_scan.sv @@
// ----------------------------------------------------------------------------
// exls_scan
// Lexer state and byte classification. Updates the scan state on each
// accepted transfer and reports the zero, one or two tokens it causes.
// ----------------------------------------------------------------------------
module exls_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          char_in_i,
  input  logic                end_of_text_i,
  output exls_pkg::scan_out_t scan_o
);
  import exls_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_IDENT,
    MODE_ERR
  } mode_e;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);
  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_CR) || (c == CH_FF) || (c == CH_VT);
  endfunction

  function automatic logic is_num_char(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
           ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) || (c == CH_UNDER);
  endfunction

  // operator kind, error for anything that is not an operator
  function automatic tok_kind_e op_kind(input logic [7:0] c);
    tok_kind_e k;
    unique case (c)
      CH_EQUAL:  k = KIND_ASSIGN;
      CH_SEMI:   k = KIND_SEMI;
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_MUL;
      CH_SLASH:  k = KIND_DIV;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      default:   k = KIND_ERROR;
    endcase
    return k;
  endfunction

  mode_e               mode_q, mode_d;
  logic [POS_BITS-1:0] cur_line_q, cur_line_d;
  logic [POS_BITS-1:0] cur_col_q, cur_col_d;
  logic [POS_BITS-1:0] tok_line_q, tok_line_d;
  logic [POS_BITS-1:0] tok_col_q, tok_col_d;
  logic [LEN_BITS-1:0] tok_len_q, tok_len_d;

  logic                in_tok;
  logic                cont;
  logic                emit_pend;
  logic                emit_byte;
  tok_kind_e           byte_kind;
  token_t              pend_tok;
  token_t              byte_tok;
  logic [POS_BITS-1:0] moved_line;
  logic [POS_BITS-1:0] moved_col;

  // position after consuming the current byte, saturating
  always_comb begin
    moved_line = cur_line_q;
    moved_col  = cur_col_q;
    if (char_in_i == CH_LF) begin
      if (cur_line_q != POS_MAX) moved_line = cur_line_q + POS_ONE;
      moved_col = POS_ONE;
    end else if (cur_col_q != POS_MAX) begin
      moved_col = cur_col_q + POS_ONE;
    end
  end

  assign in_tok = (mode_q == MODE_NUM) || (mode_q == MODE_IDENT);
  assign cont   = ((mode_q == MODE_NUM) && is_num_char(char_in_i)) ||
                  ((mode_q == MODE_IDENT) &&
                   (is_num_char(char_in_i) || is_letter(char_in_i)));
  assign byte_kind = op_kind(char_in_i);

  // next state and token selection
  always_comb begin
    mode_d     = mode_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    tok_len_d  = tok_len_q;
    emit_pend  = 1'b0;
    emit_byte  = 1'b0;

    pend_tok.kind   = (mode_q == MODE_NUM) ? KIND_NUMBER : KIND_IDENT;
    pend_tok.line   = tok_line_q;
    pend_tok.column = tok_col_q;
    pend_tok.len    = tok_len_q;
    pend_tok.last   = 1'b0;

    byte_tok.kind   = byte_kind;
    byte_tok.line   = cur_line_q;
    byte_tok.column = cur_col_q;
    byte_tok.len    = LEN_ONE;
    byte_tok.last   = 1'b1;

    if (fire_i) begin
      if (end_of_text_i) begin
        // flush, report end, return to reset values
        emit_pend     = in_tok;
        emit_byte     = 1'b1;
        byte_tok.kind = KIND_END;
        byte_tok.len  = '0;
        mode_d        = MODE_IDLE;
        cur_line_d    = POS_ONE;
        cur_col_d     = POS_ONE;
        tok_line_d    = '0;
        tok_col_d     = '0;
        tok_len_d     = '0;
      end else if (mode_q != MODE_ERR) begin
        if (in_tok && cont) begin
          // token grows
          if (tok_len_q != LEN_MAX) tok_len_d = tok_len_q + LEN_ONE;
          cur_line_d = moved_line;
          cur_col_d  = moved_col;
        end else begin
          emit_pend = in_tok;
          mode_d    = MODE_IDLE;
          priority if (is_ws(char_in_i)) begin
            cur_line_d = moved_line;
            cur_col_d  = moved_col;
          end else if (is_num_char(char_in_i) || is_letter(char_in_i)) begin
            mode_d     = is_num_char(char_in_i) ? MODE_NUM : MODE_IDENT;
            tok_line_d = cur_line_q;
            tok_col_d  = cur_col_q;
            tok_len_d  = LEN_ONE;
            cur_line_d = moved_line;
            cur_col_d  = moved_col;
          end else if (byte_kind != KIND_ERROR) begin
            emit_byte  = 1'b1;
            cur_line_d = moved_line;
            cur_col_d  = moved_col;
          end else begin
            // invalid byte, hold until end of text
            emit_byte = 1'b1;
            mode_d    = MODE_ERR;
          end
        end
      end
    end
  end

  // pack tokens, first one in slot first, last flag on the final one
  always_comb begin
    scan_o = '0;
    if (emit_pend && emit_byte) begin
      scan_o.count  = 2'd2;
      scan_o.first  = pend_tok;
      scan_o.second = byte_tok;
    end else if (emit_pend) begin
      scan_o.count      = 2'd1;
      scan_o.first      = pend_tok;
      scan_o.first.last = 1'b1;
    end else if (emit_byte) begin
      scan_o.count = 2'd1;
      scan_o.first = byte_tok;
    end
  end

  // scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      cur_line_q <= POS_ONE;
      cur_col_q  <= POS_ONE;
      tok_line_q <= '0;
      tok_col_q  <= '0;
      tok_len_q  <= '0;
    end else begin
      mode_q     <= mode_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      tok_len_q  <= tok_len_d;
    end
  end

endmodule

@@ rtl/exls_outq.sv @@
// ----------------------------------------------------------------------------
// exls_outq
// Two-slot result queue: a head register that drives the output channel
// and a second slot for the other token of a two-token transfer.
// ----------------------------------------------------------------------------
module exls_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  exls_pkg::scan_out_t scan_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output exls_pkg::token_t    head_o
);
  import exls_pkg::*;

  logic   head_vld_q;
  logic   spare_vld_q;
  token_t head_q;
  token_t spare_q;
  logic   pop;

  assign pop         = head_vld_q && out_ready_i;
  assign room_o      = !spare_vld_q && (!head_vld_q || pop);
  assign out_valid_o = head_vld_q;
  assign head_o      = head_q;

  // valid flags, a push only happens while the spare slot is empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q  <= 1'b0;
      spare_vld_q <= 1'b0;
    end else begin
      if (push_i && (scan_i.count != 2'd0)) begin
        head_vld_q  <= 1'b1;
        spare_vld_q <= (scan_i.count == 2'd2);
      end else if (pop) begin
        head_vld_q  <= spare_vld_q;
        spare_vld_q <= 1'b0;
      end
    end
  end

  // payload slots
  always_ff @(posedge clk_i) begin
    if (push_i && (scan_i.count != 2'd0)) begin
      head_q <= scan_i.first;
      if (scan_i.count == 2'd2) spare_q <= scan_i.second;
    end else if (pop && spare_vld_q) begin
      head_q <= spare_q;
    end
  end

endmodule
